/* sv/ps2ht_pkg.sv */
// ----------------------------------------------------------------------------
// ps2ht_pkg
// Shared types and constants for the PS/2 host byte transceiver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ps2ht_pkg;

    localparam int TIMER_W  = 16;
    localparam int CFG_IDX_W = 3;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INHIBIT       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SETUP         = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_WAIT     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RX_RELEASE    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RX_START_DLY  = 3'd5;

    // Reset values of the timing registers, in ticks
    localparam logic [TIMER_W-1:0] RST_RELEASE      = 16'd300;
    localparam logic [TIMER_W-1:0] RST_INHIBIT      = 16'd300;
    localparam logic [TIMER_W-1:0] RST_SETUP        = 16'd10;
    localparam logic [TIMER_W-1:0] RST_STOP_WAIT    = 16'd50;
    localparam logic [TIMER_W-1:0] RST_RX_RELEASE   = 16'd50;
    localparam logic [TIMER_W-1:0] RST_RX_START_DLY = 16'd5;

    typedef enum logic [4:0] {
        PH_IDLE      = 5'd0,
        PH_TX_REL    = 5'd1,
        PH_TX_INH    = 5'd2,
        PH_TX_SETUP  = 5'd3,
        PH_TX_START  = 5'd4,
        PH_TX_BIT_HI = 5'd5,
        PH_TX_BIT_LO = 5'd6,
        PH_TX_PAR_HI = 5'd7,
        PH_TX_PAR_LO = 5'd8,
        PH_TX_STOP   = 5'd9,
        PH_TX_ACK    = 5'd10,
        PH_TX_IDLE   = 5'd11,
        PH_RX_REL    = 5'd12,
        PH_RX_START  = 5'd13,
        PH_RX_DELAY  = 5'd14,
        PH_RX_ST_LO  = 5'd15,
        PH_RX_BIT_HI = 5'd16,
        PH_RX_BIT_LO = 5'd17,
        PH_RX_PAR_HI = 5'd18,
        PH_RX_PAR_LO = 5'd19,
        PH_RX_STP_HI = 5'd20,
        PH_RX_STP_LO = 5'd21
    } phase_t;

    typedef struct packed {
        logic [TIMER_W-1:0] release_ticks;
        logic [TIMER_W-1:0] inhibit_ticks;
        logic [TIMER_W-1:0] setup_ticks;
        logic [TIMER_W-1:0] stop_wait_ticks;
        logic [TIMER_W-1:0] rx_release_ticks;
        logic [TIMER_W-1:0] rx_start_delay_ticks;
    } cfg_t;

    typedef struct packed {
        logic       clk_pull_low;
        logic       data_pull_low;
        logic       busy;
        logic       rx_valid;
        logic [7:0] rx_byte;
        logic       tx_done;
    } res_t;

endpackage

/* sv/ps2ht_cfg_regs.sv */
// ----------------------------------------------------------------------------
// ps2ht_cfg_regs
// Timing register file; writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ps2ht_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           wr_en,
    input  logic [ps2ht_pkg::CFG_IDX_W-1:0] wr_index,
    input  logic [ps2ht_pkg::TIMER_W-1:0]   wr_data,
    output ps2ht_pkg::cfg_t                cfg
);
    import ps2ht_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.release_ticks        <= RST_RELEASE;
            cfg_reg.inhibit_ticks        <= RST_INHIBIT;
            cfg_reg.setup_ticks          <= RST_SETUP;
            cfg_reg.stop_wait_ticks      <= RST_STOP_WAIT;
            cfg_reg.rx_release_ticks     <= RST_RX_RELEASE;
            cfg_reg.rx_start_delay_ticks <= RST_RX_START_DLY;
        end
        else if (wr_en)
        begin
            case (wr_index)
                CFG_RELEASE:      cfg_reg.release_ticks        <= wr_data;
                CFG_INHIBIT:      cfg_reg.inhibit_ticks        <= wr_data;
                CFG_SETUP:        cfg_reg.setup_ticks          <= wr_data;
                CFG_STOP_WAIT:    cfg_reg.stop_wait_ticks      <= wr_data;
                CFG_RX_RELEASE:   cfg_reg.rx_release_ticks     <= wr_data;
                CFG_RX_START_DLY: cfg_reg.rx_start_delay_ticks <= wr_data;
                default:          ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

/* sv/ps2ht_fsm.sv */
// ----------------------------------------------------------------------------
// ps2ht_fsm
// Line-level sequencer: advances one sample per step, forms the next result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ps2ht_fsm (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            step,
    input  logic            clk_level,
    input  logic            data_level,
    input  logic            send_request,
    input  logic [7:0]      tx_byte,
    input  logic            receive_request,
    input  ps2ht_pkg::cfg_t cfg,
    output ps2ht_pkg::res_t res_next
);
    import ps2ht_pkg::*;

    phase_t             phase_reg,  phase_next;
    logic [TIMER_W-1:0] timer_reg,  timer_next;
    logic [7:0]         shift_reg,  shift_next;
    logic [3:0]         count_reg,  count_next;
    logic               parity_reg, parity_next;
    logic               hold_reg,   hold_next;
    logic [7:0]         last_rx_reg, last_rx_next;
    logic               timer_zero;
    logic [3:0]         count_inc;

    assign timer_zero = (timer_reg == '0);
    assign count_inc  = count_reg + 4'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            timer_reg   <= '0;
            shift_reg   <= '0;
            count_reg   <= '0;
            parity_reg  <= 1'b1;
            hold_reg    <= 1'b0;
            last_rx_reg <= '0;
        end
        else if (step)
        begin
            phase_reg   <= phase_next;
            timer_reg   <= timer_next;
            shift_reg   <= shift_next;
            count_reg   <= count_next;
            parity_reg  <= parity_next;
            hold_reg    <= hold_next;
            last_rx_reg <= last_rx_next;
        end
    end

    // Next state
    always_comb
    begin
        phase_next   = phase_reg;
        timer_next   = timer_zero ? timer_reg : timer_reg - 16'd1;
        shift_next   = shift_reg;
        count_next   = count_reg;
        parity_next  = parity_reg;
        hold_next    = hold_reg;
        last_rx_next = last_rx_reg;

        case (phase_reg)
            PH_IDLE:
            begin
                timer_next = timer_reg;
                if (send_request)
                begin
                    shift_next  = tx_byte;
                    count_next  = '0;
                    parity_next = 1'b1;
                    hold_next   = 1'b0;
                    phase_next  = PH_TX_REL;
                    timer_next  = cfg.release_ticks;
                end
                else if (receive_request)
                begin
                    shift_next = '0;
                    count_next = '0;
                    hold_next  = 1'b0;
                    phase_next = PH_RX_REL;
                    timer_next = cfg.rx_release_ticks;
                end
            end
            PH_TX_REL:
                if (timer_zero)
                begin
                    phase_next = PH_TX_INH;
                    timer_next = cfg.inhibit_ticks;
                end
            PH_TX_INH:
                if (timer_zero)
                begin
                    phase_next = PH_TX_SETUP;
                    timer_next = cfg.setup_ticks;
                end
            PH_TX_SETUP:
                if (timer_zero)
                    phase_next = PH_TX_START;
            PH_TX_START:
            begin
                timer_next = timer_reg;
                if (!clk_level)
                    phase_next = PH_TX_BIT_HI;
            end
            PH_TX_BIT_HI:
            begin
                timer_next = timer_reg;
                if (clk_level)
                    phase_next = PH_TX_BIT_LO;
            end
            PH_TX_BIT_LO:
            begin
                timer_next = timer_reg;
                if (!clk_level)
                begin
                    parity_next = parity_reg ^ shift_reg[0];
                    shift_next  = {1'b0, shift_reg[7:1]};
                    count_next  = count_inc;
                    phase_next  = count_inc[3] ? PH_TX_PAR_HI : PH_TX_BIT_HI;
                end
            end
            PH_TX_PAR_HI:
            begin
                timer_next = timer_reg;
                if (clk_level)
                    phase_next = PH_TX_PAR_LO;
            end
            PH_TX_PAR_LO:
            begin
                timer_next = timer_reg;
                if (!clk_level)
                begin
                    phase_next = PH_TX_STOP;
                    timer_next = cfg.stop_wait_ticks;
                end
            end
            PH_TX_STOP:
                if (timer_zero)
                    phase_next = PH_TX_ACK;
            PH_TX_ACK:
            begin
                timer_next = timer_reg;
                if (!clk_level)
                    phase_next = PH_TX_IDLE;
            end
            PH_TX_IDLE:
            begin
                timer_next = timer_reg;
                if (clk_level && data_level)
                begin
                    hold_next  = 1'b1;
                    phase_next = PH_IDLE;
                end
            end
            PH_RX_REL:
                if (timer_zero)
                    phase_next = PH_RX_START;
            PH_RX_START:
            begin
                timer_next = timer_reg;
                if (!clk_level)
                begin
                    phase_next = PH_RX_DELAY;
                    timer_next = cfg.rx_start_delay_ticks;
                end
            end
            PH_RX_DELAY:
                if (timer_zero)
                    phase_next = PH_RX_ST_LO;
            PH_RX_ST_LO:
            begin
                timer_next = timer_reg;
                if (clk_level)
                    phase_next = PH_RX_BIT_HI;
            end
            PH_RX_BIT_HI:
            begin
                timer_next = timer_reg;
                if (!clk_level)
                begin
                    shift_next = {data_level, shift_reg[7:1]};
                    phase_next = PH_RX_BIT_LO;
                end
            end
            PH_RX_BIT_LO:
            begin
                timer_next = timer_reg;
                if (clk_level)
                begin
                    count_next = count_inc;
                    phase_next = count_inc[3] ? PH_RX_PAR_HI : PH_RX_BIT_HI;
                end
            end
            PH_RX_PAR_HI:
            begin
                timer_next = timer_reg;
                if (!clk_level)
                    phase_next = PH_RX_PAR_LO;
            end
            PH_RX_PAR_LO:
            begin
                timer_next = timer_reg;
                if (clk_level)
                    phase_next = PH_RX_STP_HI;
            end
            PH_RX_STP_HI:
            begin
                timer_next = timer_reg;
                if (!clk_level)
                    phase_next = PH_RX_STP_LO;
            end
            PH_RX_STP_LO:
            begin
                timer_next = timer_reg;
                if (clk_level)
                begin
                    last_rx_next = shift_reg;
                    hold_next    = 1'b1;
                    phase_next   = PH_IDLE;
                end
            end
            default:
            begin
                timer_next = timer_reg;
                phase_next = PH_IDLE;
                hold_next  = 1'b0;
            end
        endcase
    end

    // Outputs, taken from the state after this step
    always_comb
    begin
        res_next.clk_pull_low  = 1'b0;
        res_next.data_pull_low = 1'b0;
        case (phase_next)
            PH_IDLE:      res_next.clk_pull_low = hold_next;
            PH_TX_INH:    res_next.clk_pull_low = 1'b1;
            PH_TX_SETUP:
            begin
                res_next.clk_pull_low  = 1'b1;
                res_next.data_pull_low = 1'b1;
            end
            PH_TX_START:  res_next.data_pull_low = 1'b1;
            PH_TX_BIT_HI,
            PH_TX_BIT_LO: res_next.data_pull_low = ~shift_next[0];
            PH_TX_PAR_HI,
            PH_TX_PAR_LO: res_next.data_pull_low = ~parity_next;
            default:      ;
        endcase
        res_next.busy     = (phase_next != PH_IDLE);
        res_next.rx_valid = (phase_reg == PH_RX_STP_LO) && (phase_next == PH_IDLE);
        res_next.tx_done  = (phase_reg == PH_TX_IDLE) && (phase_next == PH_IDLE);
        res_next.rx_byte  = last_rx_next;
    end

endmodule

/* sv/ps2_host_byte_transceiver.sv */
// ----------------------------------------------------------------------------
// ps2_host_byte_transceiver: PS/2 host byte send/receive, one line sample per transaction
// Result: registered, valid in the cycle after the input transaction is accepted.
// Throughput: 1 transaction per cycle unless a held result (out_ready low) stalls; set by the single phase update.
// Reset (async, rst_n low): idle, both lines released, timings at defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ps2_host_byte_transceiver (
    input  logic                            clk,
    input  logic                            rst_n,
    // sample channel
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            clk_level,
    input  logic                            data_level,
    input  logic                            send_request,
    input  logic [7:0]                      tx_byte,
    input  logic                            receive_request,
    // result channel
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            clk_pull_low,
    output logic                            data_pull_low,
    output logic                            busy_res,
    output logic                            rx_valid,
    output logic [7:0]                      rx_byte,
    output logic                            tx_done,
    // configuration write channel
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [ps2ht_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ps2ht_pkg::TIMER_W-1:0]   cfg_data
);
    import ps2ht_pkg::*;

    cfg_t cfg;
    res_t res_next;
    res_t res_reg;
    logic out_valid_reg;
    logic step;

    // Config is always accepted; the host only writes while idle (not enforced by this block).
    assign cfg_ready = 1'b1;

    // The result register frees when its transaction is taken, so a new
    // sample can enter in the same cycle the old result leaves.
    assign in_ready = !out_valid_reg || out_ready;
    assign step     = in_valid && in_ready;

    ps2ht_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // Sequencer state advances only on an accepted sample transaction.
    ps2ht_fsm u_fsm (
        .clk             (clk),
        .rst_n           (rst_n),
        .step            (step),
        .clk_level       (clk_level),
        .data_level      (data_level),
        .send_request    (send_request),
        .tx_byte         (tx_byte),
        .receive_request (receive_request),
        .cfg             (cfg),
        .res_next        (res_next)
    );

    // Result register: one result per accepted sample.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            res_reg       <= '0;
        end
        else
        begin
            if (step)
            begin
                out_valid_reg <= 1'b1;
                res_reg       <= res_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign clk_pull_low  = res_reg.clk_pull_low;
    assign data_pull_low = res_reg.data_pull_low;
    assign busy_res      = res_reg.busy;
    assign rx_valid      = res_reg.rx_valid;
    assign rx_byte       = res_reg.rx_byte;
    assign tx_done       = res_reg.tx_done;

`ifndef NO_ASSERTIONS
    // Every accepted sample yields a result next cycle.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> out_valid)
        else $error("accepted sample produced no result");

    // A send and a receive never finish on the same tick.
    a_one_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(rx_valid && tx_done))
        else $error("rx_valid and tx_done both set");

    // Completion returns to idle holding the clock low, data released.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (rx_valid || tx_done) |-> !busy_res && clk_pull_low && !data_pull_low)
        else $error("completion without idle clock hold");

    // When idle, the data line is never driven.
    a_idle_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !busy_res |-> !data_pull_low)
        else $error("data driven while idle");
`endif

endmodule
